// ----- hw/rtl/bayer_grbg_green_interpolation_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the GRBG green interpolation block
// Concurrent checks on clock/reset, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BAYER_GRBG_GREEN_INTERPOLATION_DEFINES_SVH
`define BAYER_GRBG_GREEN_INTERPOLATION_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BGI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define BGI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BGI_ASSERT_IMP(lbl, ante, cons, msg)
`define BGI_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/bgi_pkg.sv -----
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared widths, register indexes and helpers of the green interpolation block.
// ----------------------------------------------------------------------------
package bgi_pkg;

   localparam int PIX_W     = 8;
   localparam int DIM_W     = 12;
   localparam int MTH_W     = 2;
   localparam int SCL_W     = 7;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 12;
   localparam int DIV_NUM_W = 18;
   localparam int DIV_DEN_W = 10;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam logic [CSR_AW-1:0] CSR_WIDTH   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_HEIGHT  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_METHOD  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_SCALE_X = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_SCALE_Y = 3'd4;

   localparam logic [MTH_W-1:0] METHOD_BILINEAR = 2'd0;
   localparam logic [MTH_W-1:0] METHOD_EDGE     = 2'd1;
   localparam logic [MTH_W-1:0] METHOD_GRAD     = 2'd2;

   localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd640;
   localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd480;
   localparam logic [SCL_W-1:0] RST_SCALE  = 7'd1;

   // sum of three 8-bit samples divided by 3: reciprocal 683/2048, exact up to 765
   function automatic logic [PIX_W-1:0] div3(input logic [9:0] s);
      logic [20:0] p;
      p = {11'b0, s} * 21'd683;
      return p[18:11];
   endfunction

endpackage

// ----- hw/rtl/bgi_linebuf.sv -----
// ----------------------------------------------------------------------------
// bgi_linebuf
// One line of samples: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bgi_linebuf #(
   parameter int DEPTH = bgi_pkg::DEF_MAX_WIDTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bgi_pkg::PIX_W-1:0]   wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr_a,
   input  logic [AW-1:0]               rd_addr_b,
   output logic [bgi_pkg::PIX_W-1:0]   rd_data_a,
   output logic [bgi_pkg::PIX_W-1:0]   rd_data_b
);
   import bgi_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_a_ff;
   logic [PIX_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hw/rtl/bgi_div.sv -----
// ----------------------------------------------------------------------------
// bgi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgi_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [bgi_pkg::DIV_NUM_W-1:0]     dividend,
   input  logic [bgi_pkg::DIV_DEN_W-1:0]     divisor,
   output logic [bgi_pkg::DIV_NUM_W-1:0]     quotient,
   output logic [bgi_pkg::DIV_DEN_W-1:0]     remainder,
   output logic                              done
);
   import bgi_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ----- hw/rtl/bayer_grbg_green_interpolation.sv -----
// ----------------------------------------------------------------------------
// bayer_grbg_green_interpolation
// Green plane of a GRBG Bayer raster stream, as an 8-bit gray image.
// ----------------------------------------------------------------------------
// Takes one raw sample per request in raster order and returns the green value
// of each pixel (interpolated at red and blue sites). At full resolution
// (scale_x = scale_y = 1) output row r leaves while input row r+1 arrives;
// after the frame, requests with tuser set drain the last row, one pixel each.
// In downsample mode each result is the average of a green sample and its
// lower-right neighbor, every scale_x columns and scale_y rows.
// A request is accepted in the idle state, which issues the line-buffer reads,
// then passes a second read for the left neighbor, a compute state and, with a
// result, an output state that stalls on back-pressure; requests the frame
// logic ignores end in the idle state. A gradient-weighted interior pixel
// adds a multiply state, a divider start state and a wait state in which the
// 18-step serial divider runs and reports done. After reset and every write
// to a known register the block checks that the scales divide the frame size
// (same divider) with req_tready low. The user must write configuration only
// while idle, unchecked by the block; known-register writes restart the frame.
// ----------------------------------------------------------------------------
`include "bayer_grbg_green_interpolation_defines.svh"

module bayer_grbg_green_interpolation #(
   parameter int MAX_WIDTH  = bgi_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bgi_pkg::DEF_MAX_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   // register write port
   input  logic                         csr_we,
   input  logic [bgi_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [bgi_pkg::CSR_DW-1:0]   csr_wdata,
   // request stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bgi_pkg::PIX_W-1:0]    req_tdata,   // [7:0] pixel
   input  logic                         req_tuser,   // flush
   // result stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bgi_pkg::PIX_W-1:0]    rsp_tdata,   // [7:0] gray
   output logic                         rsp_tlast,   // end_of_line
   output logic                         rsp_tuser    // end_of_frame
);
   import bgi_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   // compare width: holds any counter or dimension plus one
   localparam int XW = ((CW > DIM_W) ? CW : DIM_W) + 1;

   typedef enum logic [3:0] {
      S_CHKS, S_CHKX, S_CHKY, S_IDLE, S_RD, S_CALC, S_MUL, S_DIVS, S_DIVW, S_OUT
   } state_type;

   typedef enum logic [1:0] {K_MID, K_AVG2, K_AVG3, K_INT} kind_type;

   // control
   state_type        state_ff, state_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [MTH_W-1:0] method_ff, method_in;
   logic [SCL_W-1:0] sx_ff, sx_in;
   logic [SCL_W-1:0] sy_ff, sy_in;
   logic             remx_ok_ff, remx_ok_in;
   logic             remy_ok_ff, remy_ok_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    drain_ff, drain_in;
   logic             draining_ff, draining_in;
   logic [SCL_W-1:0] cph_ff, cph_in;
   logic [SCL_W-1:0] rph_ff, rph_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_user_ff, rsp_user_in;

   // payload
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic             flush_ff, flush_in;
   logic [PIX_W-1:0] right_ff, right_in;
   logic [PIX_W:0]   vs_ff, vs_in;
   logic [PIX_W:0]   hs_ff, hs_in;
   logic [PIX_W-1:0] dv_ff, dv_in;
   logic [PIX_W-1:0] dh_ff, dh_in;
   logic [16:0]      p1_ff, p1_in;
   logic [16:0]      p2_ff, p2_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [PIX_W-1:0] res_ff, res_in;
   logic             res_eol_ff, res_eol_in;
   logic             res_eof_ff, res_eof_in;

   // line buffers
   logic             lb_we, u_re, m_re;
   logic [CW-1:0]    col_sel, cur_c;
   logic [CW-1:0]    u_ra, u_rb, m_ra, m_rb;
   logic [PIX_W-1:0] u_rd_a, u_rd_b, m_rd_a, m_rd_b;

   // divider
   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quo;
   logic [DIV_DEN_W-1:0] div_den, div_rem;

   // status
   logic full_mode, size_ok, scale_ok, accept, take;

   // datapath
   logic [PIX_W-1:0] left, down, up, mid;
   logic [XW-1:0]    w_x, h_x, rr_x;
   logic             is_top, is_bot, codd, c_first, c_last;
   kind_type         kind;
   logic [PIX_W:0]   a2_sum;
   logic [9:0]       a3_sum;
   logic [PIX_W:0]   vs_c, hs_c;
   logic [PIX_W-1:0] dv_c, dh_c, a4_c, int_val, val_full;
   logic [9:0]       s4;
   logic             need_div;
   logic [PIX_W:0]   ds_sum;
   logic             ds_hit, ds_eol, ds_eof;
   logic             has_out, eol_c, eof_c;
   logic [PIX_W-1:0] val_c;
   logic [XW-1:0]    col_nx, row_nx;

   bgi_linebuf #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
      .clock     (clock),
      .wr_en     (lb_we),
      .wr_addr   (col_ff),
      .wr_data   (m_rd_a),
      .rd_en     (u_re),
      .rd_addr_a (u_ra),
      .rd_addr_b (u_rb),
      .rd_data_a (u_rd_a),
      .rd_data_b (u_rd_b)
   );

   bgi_linebuf #(.DEPTH(MAX_WIDTH), .AW(CW)) u_middle (
      .clock     (clock),
      .wr_en     (lb_we),
      .wr_addr   (col_ff),
      .wr_data   (pix_ff),
      .rd_en     (m_re),
      .rd_addr_a (m_ra),
      .rd_addr_b (m_rb),
      .rd_data_a (m_rd_a),
      .rd_data_b (m_rd_b)
   );

   bgi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_den),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // ---------------------------------------------------------------- status
   assign full_mode = (sx_ff == SCL_W'(1)) && (sy_ff == SCL_W'(1));
   assign size_ok   = (width_ff >= DIM_W'(4)) && (32'(width_ff) <= MAX_WIDTH) && !width_ff[0]
                   && (height_ff >= DIM_W'(4)) && (32'(height_ff) <= MAX_HEIGHT)
                   && !height_ff[0];
   assign scale_ok  = (sx_ff >= SCL_W'(2)) && (sy_ff >= SCL_W'(2)) && !sx_ff[0] && !sy_ff[0]
                   && remx_ok_ff && remy_ok_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   // requests that the frame logic ignores never leave the idle state
   assign take = accept && size_ok &&
                 (full_mode ? (!req_tuser || draining_ff) : (scale_ok && !req_tuser));

   // ---------------------------------------------------------------- addresses
   // flush requests walk the drain column, pixels the write column
   assign cur_c   = flush_ff ? drain_ff : col_ff;
   assign col_sel = (state_ff == S_IDLE) ? (req_tuser ? drain_ff : col_ff) : cur_c;
   assign u_ra    = col_sel;
   assign u_rb    = col_sel - CW'(1);
   assign m_ra    = col_sel;
   // second read fetches the left neighbor of the middle line
   assign m_rb    = (state_ff == S_RD) ? (cur_c - CW'(1)) : (col_sel + CW'(1));

   // ---------------------------------------------------------------- full-res value
   // up = row above, mid = this pixel, down = row below (the incoming sample)
   assign up   = u_rd_a;
   assign mid  = m_rd_a;
   assign left = flush_ff ? m_rd_b : u_rd_b;
   assign down = flush_ff ? '0 : pix_ff;

   assign w_x     = XW'(width_ff);
   assign h_x     = XW'(height_ff);
   assign rr_x    = flush_ff ? (h_x - XW'(1)) : (XW'(row_ff) - XW'(1));
   assign is_top  = (rr_x == '0);
   assign is_bot  = (rr_x == h_x - XW'(1));
   assign codd    = cur_c[0];
   assign c_first = (cur_c == '0);
   assign c_last  = (XW'(cur_c) == w_x - XW'(1));

   always_comb begin
      kind   = K_MID;
      a2_sum = '0;
      a3_sum = '0;
      if (is_top) begin
         // red sites of the top row
         if (codd) begin
            if (c_last) begin
               kind   = K_AVG2;
               a2_sum = {1'b0, left} + {1'b0, down};
            end else begin
               kind   = K_AVG3;
               a3_sum = {2'b0, left} + {2'b0, right_ff} + {2'b0, down};
            end
         end
      end else if (is_bot) begin
         // blue sites of the bottom row
         if (!codd) begin
            if (c_first) begin
               kind   = K_AVG2;
               a2_sum = {1'b0, right_ff} + {1'b0, up};
            end else begin
               kind   = K_AVG3;
               a3_sum = {2'b0, left} + {2'b0, right_ff} + {2'b0, up};
            end
         end
      end else if (rr_x[0]) begin
         if (!codd) begin
            if (c_first) begin
               kind   = K_AVG3;
               a3_sum = {2'b0, up} + {2'b0, down} + {2'b0, right_ff};
            end else begin
               kind = K_INT;
            end
         end
      end else begin
         if (codd) begin
            if (c_last) begin
               kind   = K_AVG3;
               a3_sum = {2'b0, up} + {2'b0, down} + {2'b0, left};
            end else begin
               kind = K_INT;
            end
         end
      end
   end

   // interior: vertical pair up/down, horizontal pair left/right
   assign vs_c = {1'b0, up} + {1'b0, down};
   assign hs_c = {1'b0, left} + {1'b0, right_ff};
   assign dv_c = (up > down) ? (up - down) : (down - up);
   assign dh_c = (left > right_ff) ? (left - right_ff) : (right_ff - left);
   assign s4   = {1'b0, vs_c} + {1'b0, hs_c};
   assign a4_c = s4[9:2];

   always_comb begin
      int_val  = a4_c;
      need_div = 1'b0;
      case (method_ff)
         METHOD_EDGE: begin
            if (dh_c > dv_c) begin
               int_val = vs_c[PIX_W:1];
            end else if (dv_c > dh_c) begin
               int_val = hs_c[PIX_W:1];
            end
         end
         METHOD_GRAD: begin
            need_div = (dv_c != '0) || (dh_c != '0);
         end
         default: int_val = a4_c;
      endcase
   end

   always_comb begin
      case (kind)
         K_AVG2:  val_full = a2_sum[PIX_W:1];
         K_AVG3:  val_full = div3(a3_sum);
         K_INT:   val_full = int_val;
         default: val_full = mid;
      endcase
   end

   // ---------------------------------------------------------------- downsample
   assign ds_sum = {1'b0, u_rd_b} + {1'b0, pix_ff};
   assign ds_hit = (rph_ff == SCL_W'(1)) && (cph_ff == SCL_W'(1));
   assign ds_eol = (XW'(col_ff) == w_x - XW'(sx_ff) + XW'(1));
   assign ds_eof = ds_eol && (XW'(row_ff) == h_x - XW'(sy_ff) + XW'(1));

   assign col_nx = XW'(col_ff) + XW'(1);
   assign row_nx = XW'(row_ff) + XW'(1);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      method_in    = method_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      remx_ok_in   = remx_ok_ff;
      remy_ok_in   = remy_ok_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      drain_in     = drain_ff;
      draining_in  = draining_ff;
      cph_in       = cph_ff;
      rph_in       = rph_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      pix_in       = pix_ff;
      flush_in     = flush_ff;
      right_in     = right_ff;
      vs_in        = vs_ff;
      hs_in        = hs_ff;
      dv_in        = dv_ff;
      dh_in        = dh_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      den_in       = den_ff;
      res_in       = res_ff;
      res_eol_in   = res_eol_ff;
      res_eof_in   = res_eof_ff;
      lb_we        = 1'b0;
      u_re         = 1'b0;
      m_re         = 1'b0;
      div_start    = 1'b0;
      div_num      = DIV_NUM_W'(width_ff);
      div_den      = DIV_DEN_W'(sx_ff);
      has_out      = 1'b0;
      eol_c        = 1'b0;
      eof_c        = 1'b0;
      val_c        = val_full;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CHKS: begin
            // width divisibility by scale_x first
            div_start = 1'b1;
            state_in  = S_CHKX;
         end
         S_CHKX: begin
            if (div_done) begin
               remx_ok_in = (div_rem == '0);
               div_start  = 1'b1;
               div_num    = DIV_NUM_W'(height_ff);
               div_den    = DIV_DEN_W'(sy_ff);
               state_in   = S_CHKY;
            end
         end
         S_CHKY: begin
            if (div_done) begin
               remy_ok_in = (div_rem == '0);
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (take) begin
               pix_in   = req_tdata;
               flush_in = req_tuser;
               u_re     = 1'b1;
               m_re     = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            right_in = m_rd_b;
            m_re     = 1'b1;
            state_in = S_CALC;
         end
         S_CALC: begin
            if (full_mode && flush_ff) begin
               // drain one pixel of the last row
               has_out  = 1'b1;
               eol_c    = (XW'(cur_c) + XW'(1) >= w_x);
               eof_c    = eol_c;
               drain_in = cur_c + CW'(1);
               if (eol_c) begin
                  drain_in    = '0;
                  draining_in = 1'b0;
               end
            end else begin
               if (full_mode) begin
                  has_out = (row_ff != '0);
                  eol_c   = c_last;
               end else begin
                  has_out = ds_hit;
                  val_c   = ds_sum[PIX_W:1];
                  eol_c   = ds_eol;
                  eof_c   = ds_eof;
               end
               // shift the column down one line and advance the raster position
               lb_we       = 1'b1;
               draining_in = 1'b0;
               drain_in    = '0;
               col_in      = col_ff + CW'(1);
               cph_in      = (cph_ff + SCL_W'(1) == sx_ff) ? '0 : cph_ff + SCL_W'(1);
               if (col_nx >= w_x) begin
                  col_in = '0;
                  cph_in = '0;
                  row_in = row_ff + RW'(1);
                  rph_in = (rph_ff + SCL_W'(1) == sy_ff) ? '0 : rph_ff + SCL_W'(1);
                  if (row_nx >= h_x) begin
                     row_in      = '0;
                     rph_in      = '0;
                     draining_in = full_mode;
                  end
               end
            end
            res_in     = val_c;
            res_eol_in = eol_c;
            res_eof_in = eof_c;
            vs_in      = vs_c;
            hs_in      = hs_c;
            dv_in      = dv_c;
            dh_in      = dh_c;
            den_in     = {({1'b0, dh_c} + {1'b0, dv_c}), 1'b0};
            if (!has_out) begin
               state_in = S_IDLE;
            end else if (full_mode && (kind == K_INT) && need_div) begin
               state_in = S_MUL;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MUL: begin
            p1_in    = {8'b0, vs_ff} * {9'b0, dh_ff};
            p2_in    = {8'b0, hs_ff} * {9'b0, dv_ff};
            state_in = S_DIVS;
         end
         S_DIVS: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(p1_ff) + DIV_NUM_W'(p2_ff);
            div_den   = den_ff;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               res_in   = div_quo[PIX_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_last_in  = res_eol_ff;
               rsp_user_in  = res_eof_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // any known register write restarts the frame and re-runs the scale check
      if (csr_we) begin
         unique case (csr_addr)
            CSR_WIDTH:   width_in  = csr_wdata[DIM_W-1:0];
            CSR_HEIGHT:  height_in = csr_wdata[DIM_W-1:0];
            CSR_METHOD:  method_in = csr_wdata[MTH_W-1:0];
            CSR_SCALE_X: sx_in     = csr_wdata[SCL_W-1:0];
            CSR_SCALE_Y: sy_in     = csr_wdata[SCL_W-1:0];
            default: ;
         endcase
         if (csr_addr <= CSR_SCALE_Y) begin
            col_in      = '0;
            row_in      = '0;
            drain_in    = '0;
            draining_in = 1'b0;
            cph_in      = '0;
            rph_in      = '0;
            state_in    = S_CHKS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CHKS;
         width_ff     <= RST_WIDTH;
         height_ff    <= RST_HEIGHT;
         method_ff    <= METHOD_BILINEAR;
         sx_ff        <= RST_SCALE;
         sy_ff        <= RST_SCALE;
         remx_ok_ff   <= 1'b0;
         remy_ok_ff   <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         drain_ff     <= '0;
         draining_ff  <= 1'b0;
         cph_ff       <= '0;
         rph_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
         rsp_last_ff  <= 1'b0;
         rsp_user_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         method_ff    <= method_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         remx_ok_ff   <= remx_ok_in;
         remy_ok_ff   <= remy_ok_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         drain_ff     <= drain_in;
         draining_ff  <= draining_in;
         cph_ff       <= cph_in;
         rph_ff       <= rph_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_user_ff  <= rsp_user_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff     <= pix_in;
      flush_ff   <= flush_in;
      right_ff   <= right_in;
      vs_ff      <= vs_in;
      hs_ff      <= hs_in;
      dv_ff      <= dv_in;
      dh_ff      <= dh_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      den_ff     <= den_in;
      res_ff     <= res_in;
      res_eol_ff <= res_eol_in;
      res_eof_ff <= res_eof_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------------------------------------------------------- checks
   `BGI_ASSERT_IMP(a_wr_pixel_only, lb_we, (state_ff == S_CALC) && !flush_ff,
                   "line buffer written outside a pixel request")
   `BGI_ASSERT_IMP(a_drain_full_res, draining_ff, full_mode,
                   "drain pending in downsample mode")
   `BGI_ASSERT_NXT(a_rsp_load, (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready),
                   rsp_valid_ff && (rsp_data_ff == $past(res_ff)),
                   "result not moved to output register")

endmodule
